// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the cursor list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define CLE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define CLE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/cle_pkg.sv =====
// Package with the sizes, codes and types of the cursor list engine.
`default_nettype none

package cle_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int PTR_W      = IDX_W + 1;
  localparam int CNT_W      = PTR_W;

  // Null pointer: one past the last node of the pool.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  typedef enum logic [3:0] {
    OP_QUERY     = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_FRONT     = 4'd2,
    OP_BACK      = 4'd3,
    OP_PREV      = 4'd4,
    OP_NEXT      = 4'd5,
    OP_PREPEND   = 4'd6,
    OP_APPEND    = 4'd7,
    OP_BEFORE    = 4'd8,
    OP_AFTER     = 4'd9,
    OP_DELFRONT  = 4'd10,
    OP_DELBACK   = 4'd11,
    OP_DELCURSOR = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOCURSOR = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== src/cle_ram.sv =====
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/cursor_list_engine.sv =====
// Cursor list engine: a doubly linked list of signed words with a cursor.
// Each input transfer carries an opcode and a data value; each one yields
// exactly one result transfer with the status, the list length, the cursor
// position and the values at the cursor, the front and the back.
// Both channels use valid and stall; a transfer happens on a rising edge
// with valid high and stall low. The input stalls while an item is at work.
// Query, clear, front, back and every failing operation go from the input
// transfer straight to the result step. Moves, insertions and deletions
// pass through a read, an execute and a write-back step: the link memories
// are read, then rewritten, and a node value is fetched once more for the
// cursor or a new end of the list. One item is at work at a time; the
// result register lets the next item be taken while an earlier result
// still waits; a finished item holds in its last step until the result
// register is free. Synchronous active-low reset empties the list,
// undefines the cursor and drops any pending result; the node memories
// need no clearing.
`default_nettype none
`include "assert_macros.svh"

module cursor_list_engine import cle_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [3:0]                  in_opcode,
  input  wire logic signed [DATA_WIDTH-1:0] in_data_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [CNT_W-1:0]                 out_list_length,
  output logic signed [PTR_W-1:0]          out_cursor_position,
  output logic signed [DATA_WIDTH-1:0]     out_cursor_value,
  output logic signed [DATA_WIDTH-1:0]     out_front_value,
  output logic signed [DATA_WIDTH-1:0]     out_back_value
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EX   = 5'b00100,
    S_WB   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [DATA_WIDTH-1:0]  data_r;
  logic [PTR_W-1:0]       addr_r;
  logic [PTR_W-1:0]       p_r, n_r, x_r;
  logic                   mv_r;
  status_t                status_r;

  logic [PTR_W-1:0]       front_r, back_r, cur_r;
  logic [PTR_W-1:0]       pos_r;
  logic [CNT_W-1:0]       cnt_r, fc_r, mark_r;
  logic [DATA_WIDTH-1:0]  front_val_r, back_val_r, cur_val_r;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [CNT_W-1:0]       out_len_r;
  logic [PTR_W-1:0]       out_pos_r;
  logic [DATA_WIDTH-1:0]  out_cur_r, out_front_r, out_back_r;

  // Memory ports.
  logic                   nv_we, nn_we, np_we, fs_we;
  logic [IDX_W-1:0]       nv_wa, nn_wa, np_wa, fs_wa, nv_ra;
  logic [DATA_WIDTH-1:0]  nv_wd, nv_rd;
  logic [PTR_W-1:0]       nn_wd, np_wd, nn_rd, np_rd;
  logic [IDX_W-1:0]       fs_wd, fs_rd;

  cle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value (
    .clk(clk), .wr_en(nv_we), .wr_addr(nv_wa), .wr_data(nv_wd),
    .rd_addr(nv_ra), .rd_data(nv_rd)
  );
  cle_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .wr_en(nn_we), .wr_addr(nn_wa), .wr_data(nn_wd),
    .rd_addr(addr_r[IDX_W-1:0]), .rd_data(nn_rd)
  );
  cle_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_prev (
    .clk(clk), .wr_en(np_we), .wr_addr(np_wa), .wr_data(np_wd),
    .rd_addr(addr_r[IDX_W-1:0]), .rd_data(np_rd)
  );
  cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
    .rd_addr(IDX_W'(fc_r - CNT_W'(1))), .rd_data(fs_rd)
  );

  logic in_acc, out_free;
  logic empty, nocur, full;
  op_t  in_op;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_op    = op_t'(in_opcode);
  assign empty    = (cnt_r == '0);
  assign nocur    = (cur_r == NIL);
  assign full     = (cnt_r >= CNT_W'(CAPACITY));

  // Error check and memory need of an incoming operation.
  status_t acc_status;
  logic    acc_mem;
  logic [PTR_W-1:0] acc_addr;

  always_comb begin
    acc_status = ST_OK;
    acc_mem    = 1'b0;
    acc_addr   = cur_r;
    case (in_op)
      OP_FRONT, OP_BACK: begin
        if (empty) acc_status = ST_EMPTY;
      end
      OP_PREV, OP_NEXT, OP_BEFORE, OP_AFTER, OP_DELCURSOR: begin
        if (empty) acc_status = ST_EMPTY;
        else if (nocur) acc_status = ST_NOCURSOR;
        else if (full && (in_op == OP_BEFORE || in_op == OP_AFTER)) acc_status = ST_FULL;
      end
      OP_PREPEND, OP_APPEND: begin
        if (full) acc_status = ST_FULL;
      end
      OP_DELFRONT: begin
        if (empty) acc_status = ST_EMPTY;
        acc_addr = front_r;
      end
      OP_DELBACK: begin
        if (empty) acc_status = ST_EMPTY;
        acc_addr = back_r;
      end
      default: ;
    endcase
    if (acc_status == ST_OK) begin
      case (in_op)
        OP_QUERY, OP_CLEAR, OP_FRONT, OP_BACK: acc_mem = 1'b0;
        OP_PREV, OP_NEXT, OP_PREPEND, OP_APPEND, OP_BEFORE, OP_AFTER,
        OP_DELFRONT, OP_DELBACK, OP_DELCURSOR: acc_mem = 1'b1;
        default: acc_mem = 1'b0;
      endcase
    end
  end

  // Neighbours and the fresh or removed node of the operation at work.
  logic is_ins, is_del, is_move;
  logic [PTR_W-1:0] ex_p, ex_n, ex_x;

  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    is_move = 1'b0;
    ex_x    = (fc_r != '0) ? {1'b0, fs_rd} : mark_r;
    ex_p    = np_rd;
    ex_n    = nn_rd;
    case (op_r)
      OP_PREV, OP_NEXT: is_move = 1'b1;
      OP_PREPEND: begin
        is_ins = 1'b1;
        ex_p   = NIL;
        ex_n   = front_r;
      end
      OP_APPEND: begin
        is_ins = 1'b1;
        ex_p   = back_r;
        ex_n   = NIL;
      end
      OP_BEFORE: begin
        is_ins = 1'b1;
        ex_n   = cur_r;
      end
      OP_AFTER: begin
        is_ins = 1'b1;
        ex_p   = cur_r;
      end
      OP_DELFRONT, OP_DELBACK, OP_DELCURSOR: begin
        is_del = 1'b1;
        ex_x   = addr_r;
      end
      default: ;
    endcase
  end

  // Memory writes and the value fetch.
  logic [PTR_W-1:0] mv_tgt;
  logic             mv_edge;

  assign mv_tgt  = (op_r == OP_PREV) ? np_rd : nn_rd;
  assign mv_edge = (op_r == OP_PREV) ? (cur_r == front_r) : (cur_r == back_r);

  always_comb begin
    nv_we = 1'b0;  nv_wa = ex_x[IDX_W-1:0];  nv_wd = data_r;
    nn_we = 1'b0;  nn_wa = ex_x[IDX_W-1:0];  nn_wd = ex_n;
    np_we = 1'b0;  np_wa = ex_x[IDX_W-1:0];  np_wd = ex_p;
    fs_we = 1'b0;  fs_wa = fc_r[IDX_W-1:0];  fs_wd = ex_x[IDX_W-1:0];
    nv_ra = '0;
    if (state_r == S_EX) begin
      if (is_ins) begin
        nv_we = 1'b1;
        nn_we = 1'b1;
        np_we = 1'b1;
      end else if (is_del) begin
        nn_we = (ex_p != NIL);
        nn_wa = ex_p[IDX_W-1:0];
        np_we = (ex_n != NIL);
        np_wa = ex_n[IDX_W-1:0];
        fs_we = (fc_r < CNT_W'(CAPACITY));
        nv_ra = (ex_p == NIL) ? ex_n[IDX_W-1:0] : ex_p[IDX_W-1:0];
      end else if (is_move) begin
        nv_ra = mv_tgt[IDX_W-1:0];
      end
    end else if (state_r == S_WB && is_ins) begin
      nn_we = (p_r != NIL);
      nn_wa = p_r[IDX_W-1:0];
      nn_wd = x_r;
      np_we = (n_r != NIL);
      np_wa = n_r[IDX_W-1:0];
      np_wd = x_r;
    end
  end

  // Sequencer and list state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= NIL;
      back_r      <= NIL;
      cur_r       <= NIL;
      pos_r       <= '1;
      cnt_r       <= '0;
      fc_r        <= '0;
      mark_r      <= '0;
      front_val_r <= '0;
      back_val_r  <= '0;
      cur_val_r   <= '0;
      out_valid_r <= 1'b0;
      mv_r        <= 1'b0;
    end else begin
      // The result register empties on its transfer unless a new result loads it.
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_op;
            data_r   <= in_data_value;
            addr_r   <= acc_addr;
            status_r <= acc_status;
            mv_r     <= 1'b0;
            state_r  <= acc_mem ? S_RD : S_DONE;
            if (acc_status == ST_OK) begin
              case (in_op)
                OP_CLEAR: begin
                  front_r     <= NIL;
                  back_r      <= NIL;
                  cur_r       <= NIL;
                  pos_r       <= '1;
                  cnt_r       <= '0;
                  fc_r        <= '0;
                  mark_r      <= '0;
                  front_val_r <= '0;
                  back_val_r  <= '0;
                  cur_val_r   <= '0;
                end
                OP_FRONT: begin
                  cur_r     <= front_r;
                  pos_r     <= '0;
                  cur_val_r <= front_val_r;
                end
                OP_BACK: begin
                  cur_r     <= back_r;
                  pos_r     <= cnt_r - CNT_W'(1);
                  cur_val_r <= back_val_r;
                end
                default: ;
              endcase
            end
          end
        end
        S_RD: begin
          state_r <= S_EX;
        end
        S_EX: begin
          state_r <= S_WB;
          p_r     <= ex_p;
          n_r     <= ex_n;
          x_r     <= ex_x;
          if (is_move) begin
            if (mv_edge) begin
              cur_r     <= NIL;
              pos_r     <= '1;
              cur_val_r <= '0;
            end else begin
              cur_r <= mv_tgt;
              pos_r <= (op_r == OP_PREV) ? pos_r - PTR_W'(1) : pos_r + PTR_W'(1);
              mv_r  <= 1'b1;
            end
          end else if (is_ins) begin
            if (fc_r != '0) fc_r <= fc_r - CNT_W'(1);
            else mark_r <= mark_r + CNT_W'(1);
            cnt_r <= cnt_r + CNT_W'(1);
            if (ex_p == NIL) begin
              front_r     <= ex_x;
              front_val_r <= data_r;
            end
            if (ex_n == NIL) begin
              back_r     <= ex_x;
              back_val_r <= data_r;
            end
            if (op_r == OP_BEFORE || (op_r == OP_PREPEND && !nocur)) begin
              pos_r <= pos_r + PTR_W'(1);
            end
          end else if (is_del) begin
            if (ex_p == NIL) front_r <= ex_n;
            if (ex_n == NIL) back_r <= ex_p;
            if (ex_p == NIL && ex_n == NIL) begin
              front_val_r <= '0;
              back_val_r  <= '0;
            end
            if (fc_r < CNT_W'(CAPACITY)) fc_r <= fc_r + CNT_W'(1);
            cnt_r <= cnt_r - CNT_W'(1);
            // The cursor is lost with its node; a front deletion shifts it down.
            if (cur_r == ex_x || op_r == OP_DELCURSOR) begin
              cur_r     <= NIL;
              pos_r     <= '1;
              cur_val_r <= '0;
            end else if (op_r == OP_DELFRONT && !nocur) begin
              pos_r <= pos_r - PTR_W'(1);
            end
          end
        end
        S_WB: begin
          state_r <= S_DONE;
          // The value read in the execute step lands here, in the step after it.
          if (mv_r) cur_val_r <= nv_rd;
          if (is_del) begin
            if (p_r == NIL && n_r != NIL) front_val_r <= nv_rd;
            if (n_r == NIL && p_r != NIL) back_val_r <= nv_rd;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_len_r    <= cnt_r;
            out_pos_r    <= pos_r;
            out_cur_r    <= cur_val_r;
            out_front_r  <= front_val_r;
            out_back_r   <= back_val_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_list_length     = out_len_r;
  assign out_cursor_position = out_pos_r;
  assign out_cursor_value    = out_cur_r;
  assign out_front_value     = out_front_r;
  assign out_back_value      = out_back_r;

  // Invariants of the list state.
  `CLE_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CNT_W'(CAPACITY), "element count beyond capacity")
  `CLE_ASSERT_ALWAYS(a_cursor_pair, (cur_r == NIL) == (pos_r == '1), "cursor state split")
  `CLE_ASSERT_IMPLIES(a_empty_ends, cnt_r == '0, front_r == NIL && back_r == NIL, "stray end")
  `CLE_ASSERT_ALWAYS(a_pool_sum, ({1'b0, fc_r} + {1'b0, cnt_r}) == {1'b0, mark_r}, "node lost")

endmodule

`default_nettype wire

// ===== tb/cursor_list_engine_tb.sv =====
// Self-checking testbench for the cursor list engine, with its own list predictor.
`timescale 1ns / 100ps

module cursor_list_engine_tb;
  import cle_pkg::*;

  localparam int NODES = CAPACITY;
  localparam int NONE = CAPACITY;
  localparam logic [3:0] OP_SPARE = 4'd15;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    status_t st;
    logic [CNT_W-1:0] len;
    logic signed [PTR_W-1:0] pos;
    logic signed [DATA_WIDTH-1:0] cur;
    logic signed [DATA_WIDTH-1:0] frt;
    logic signed [DATA_WIDTH-1:0] bck;
  } list_result_t;

  typedef struct {
    logic [3:0] op;
    logic signed [DATA_WIDTH-1:0] data;
    bit typed;
    list_result_t res;
  } list_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_opcode = OP_QUERY;
  logic signed [DATA_WIDTH-1:0] in_data_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [CNT_W-1:0] out_list_length;
  logic signed [PTR_W-1:0] out_cursor_position;
  logic signed [DATA_WIDTH-1:0] out_cursor_value;
  logic signed [DATA_WIDTH-1:0] out_front_value;
  logic signed [DATA_WIDTH-1:0] out_back_value;

  cursor_list_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_data_value(in_data_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_list_length(out_list_length),
    .out_cursor_position(out_cursor_position), .out_cursor_value(out_cursor_value),
    .out_front_value(out_front_value), .out_back_value(out_back_value)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted list state.
  logic signed [DATA_WIDTH-1:0] node_val[NODES];
  int node_nxt[NODES];
  int node_prv[NODES];
  int spare_stack[NODES];
  int spare_cnt, fresh_mark, head, tail, cur_node, cur_idx, count;

  list_result_t pending_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int full_hits = 0;
  bit idle_free = 1'b0;
  bit hold_now = 1'b0;
  bit result_taken = 1'b0;
  int cycles = 0;

  function automatic void list_reset();
    spare_cnt = 0;
    fresh_mark = 0;
    head = NONE;
    tail = NONE;
    cur_node = NONE;
    cur_idx = -1;
    count = 0;
  endfunction

  // Takes a node from the spare stack, else from the untouched part of the pool.
  function automatic void link_in(int p, int n, logic signed [DATA_WIDTH-1:0] v);
    int x;
    if (spare_cnt > 0) begin
      spare_cnt--;
      x = spare_stack[spare_cnt];
    end else begin
      x = fresh_mark;
      fresh_mark++;
    end
    node_val[x] = v;
    node_prv[x] = p;
    node_nxt[x] = n;
    if (p != NONE) node_nxt[p] = x; else head = x;
    if (n != NONE) node_prv[n] = x; else tail = x;
    count++;
  endfunction

  function automatic void link_out(int x);
    int p;
    int n;
    p = node_prv[x];
    n = node_nxt[x];
    if (p != NONE) node_nxt[p] = n; else head = n;
    if (n != NONE) node_prv[n] = p; else tail = p;
    spare_stack[spare_cnt] = x;
    spare_cnt++;
    count--;
  endfunction

  function automatic void drop_cursor();
    cur_node = NONE;
    cur_idx = -1;
  endfunction

  // Applies one operation to the predicted list and returns its result.
  function automatic list_result_t list_apply(logic [3:0] op, logic signed [DATA_WIDTH-1:0] v);
    list_result_t r;
    bit empty;
    bit nocur;
    bit full;
    empty = (count == 0);
    nocur = (cur_node == NONE);
    full = (count >= NODES);
    r.st = ST_OK;
    case (op)
      OP_CLEAR: list_reset();
      OP_FRONT, OP_BACK: begin
        if (empty) r.st = ST_EMPTY;
        else if (op == OP_FRONT) begin
          cur_node = head;
          cur_idx = 0;
        end else begin
          cur_node = tail;
          cur_idx = count - 1;
        end
      end
      OP_PREV, OP_NEXT: begin
        if (empty) r.st = ST_EMPTY;
        else if (nocur) r.st = ST_NOCURSOR;
        else if (op == OP_PREV) begin
          if (cur_node == head) drop_cursor();
          else begin
            cur_node = node_prv[cur_node];
            cur_idx--;
          end
        end else begin
          if (cur_node == tail) drop_cursor();
          else begin
            cur_node = node_nxt[cur_node];
            cur_idx++;
          end
        end
      end
      OP_PREPEND: begin
        if (full) r.st = ST_FULL;
        else begin
          link_in(NONE, head, v);
          if (!nocur) cur_idx++;
        end
      end
      OP_APPEND: begin
        if (full) r.st = ST_FULL;
        else link_in(tail, NONE, v);
      end
      OP_BEFORE, OP_AFTER: begin
        if (empty) r.st = ST_EMPTY;
        else if (nocur) r.st = ST_NOCURSOR;
        else if (full) r.st = ST_FULL;
        else if (op == OP_BEFORE) begin
          link_in(node_prv[cur_node], cur_node, v);
          cur_idx++;
        end else link_in(cur_node, node_nxt[cur_node], v);
      end
      OP_DELFRONT: begin
        if (empty) r.st = ST_EMPTY;
        else begin
          if (cur_node == head) drop_cursor();
          else if (!nocur) cur_idx--;
          link_out(head);
        end
      end
      OP_DELBACK: begin
        if (empty) r.st = ST_EMPTY;
        else begin
          if (cur_node == tail) drop_cursor();
          link_out(tail);
        end
      end
      OP_DELCURSOR: begin
        if (empty) r.st = ST_EMPTY;
        else if (nocur) r.st = ST_NOCURSOR;
        else begin
          link_out(cur_node);
          drop_cursor();
        end
      end
      default: ;
    endcase
    if (r.st == ST_FULL) full_hits++;
    r.len = CNT_W'(count);
    r.pos = PTR_W'(cur_idx);
    r.cur = (cur_node != NONE) ? node_val[cur_node] : '0;
    r.frt = (head != NONE) ? node_val[head] : '0;
    r.bck = (tail != NONE) ? node_val[tail] : '0;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Drives one item and waits for its transfer; the prediction is made on acceptance.
  task automatic offer(logic [3:0] op, logic signed [DATA_WIDTH-1:0] v, bit typed,
                       list_result_t typed_res);
    int gap;
    list_result_t r;
    gap = idle_free ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_data_value <= v;
    do @(posedge clk); while (in_stall);
    r = list_apply(op, v);
    pending_q.push_back(typed ? typed_res : r);
    sent++;
  endtask

  // Random operation, weighted by the current phase: growing, shrinking or mixed.
  function automatic logic [3:0] pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return (mode == 1) ? OP_CLEAR : OP_QUERY;
    if (r == 1) return 4'(OP_SPARE - $urandom_range(0, 2));
    if (mode == 0) begin
      if (r < 25) return OP_APPEND;
      if (r < 45) return OP_PREPEND;
      if (r < 65) return OP_BEFORE;
      if (r < 85) return OP_AFTER;
    end else if (mode == 1) begin
      if (r < 30) return OP_DELFRONT;
      if (r < 55) return OP_DELBACK;
      if (r < 80) return OP_DELCURSOR;
    end else begin
      if (r < 12) return OP_APPEND;
      if (r < 22) return OP_PREPEND;
      if (r < 32) return OP_BEFORE;
      if (r < 42) return OP_AFTER;
      if (r < 50) return OP_DELFRONT;
      if (r < 57) return OP_DELBACK;
      if (r < 64) return OP_DELCURSOR;
    end
    case ($urandom_range(0, 4))
      0: return OP_FRONT;
      1: return OP_BACK;
      2: return OP_PREV;
      3: return OP_NEXT;
      default: return OP_QUERY;
    endcase
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_data();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      1: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic list_result_t res(status_t st, int len, int pos,
                                       logic signed [DATA_WIDTH-1:0] c,
                                       logic signed [DATA_WIDTH-1:0] f,
                                       logic signed [DATA_WIDTH-1:0] b);
    list_result_t r;
    r.st = st;
    r.len = CNT_W'(len);
    r.pos = PTR_W'(pos);
    r.cur = c;
    r.frt = f;
    r.bck = b;
    return r;
  endfunction

  // Stimulus: reset, directed table, then random phases.
  initial begin
    list_row_t rows[$];
    logic signed [DATA_WIDTH-1:0] top;
    logic signed [DATA_WIDTH-1:0] bot;
    list_result_t none_res;
    int mode;
    int span;
    bit paused;
    top = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    bot = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    none_res = res(ST_OK, 0, -1, 0, 0, 0);
    paused = 1'b0;
    list_reset();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    rows = '{
      '{OP_QUERY, 0, 1, res(ST_OK, 0, -1, 0, 0, 0)},
      '{OP_FRONT, 0, 1, res(ST_EMPTY, 0, -1, 0, 0, 0)},
      '{OP_PREV, 0, 1, res(ST_EMPTY, 0, -1, 0, 0, 0)},
      '{OP_BEFORE, 9, 1, res(ST_EMPTY, 0, -1, 0, 0, 0)},
      '{OP_DELCURSOR, 0, 1, res(ST_EMPTY, 0, -1, 0, 0, 0)},
      '{OP_DELFRONT, 0, 1, res(ST_EMPTY, 0, -1, 0, 0, 0)},
      '{OP_DELBACK, 0, 1, res(ST_EMPTY, 0, -1, 0, 0, 0)},
      '{OP_APPEND, top, 1, res(ST_OK, 1, -1, 0, top, top)},
      '{OP_NEXT, 0, 1, res(ST_NOCURSOR, 1, -1, 0, top, top)},
      '{OP_BEFORE, 3, 1, res(ST_NOCURSOR, 1, -1, 0, top, top)},
      '{OP_DELCURSOR, 0, 1, res(ST_NOCURSOR, 1, -1, 0, top, top)},
      '{OP_PREPEND, bot, 1, res(ST_OK, 2, -1, 0, bot, top)},
      '{OP_FRONT, 0, 1, res(ST_OK, 2, 0, bot, bot, top)},
      '{OP_PREV, 0, 1, res(ST_OK, 2, -1, 0, bot, top)},
      '{OP_BACK, 0, 1, res(ST_OK, 2, 1, top, bot, top)},
      '{OP_NEXT, 0, 1, res(ST_OK, 2, -1, 0, bot, top)},
      '{OP_BACK, 0, 0, none_res},
      '{OP_BEFORE, 5, 0, none_res},
      '{OP_AFTER, -1, 0, none_res},
      '{OP_PREPEND, 0, 0, none_res},
      '{OP_SPARE, 7, 0, none_res},
      '{OP_DELFRONT, 0, 0, none_res},
      '{OP_DELCURSOR, 0, 0, none_res},
      '{OP_DELBACK, 0, 0, none_res},
      '{OP_CLEAR, 0, 1, res(ST_OK, 0, -1, 0, 0, 0)}
    };
    foreach (rows[i]) offer(rows[i].op, rows[i].data, rows[i].typed, rows[i].res);

    // Random phases; the first growing phase is long enough to fill the pool.
    mode = 0;
    span = 500;
    while (sent < RANDOM_ITEMS + rows.size()) begin
      idle_free = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < span && sent < RANDOM_ITEMS + rows.size(); k++) begin
        offer(pick_op(mode), pick_data(), 1'b0, none_res);
        if (!paused && sent > 1200) begin
          // Let the block drain completely before carrying on.
          paused = 1'b1;
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_q.size() != 0) @(negedge clk);
        end
      end
      mode = $urandom_range(0, 2);
      span = (mode == 0) ? $urandom_range(150, 330) : $urandom_range(30, 200);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d operations and checked %0d results; the pool was full %0d times.",
             sent, received, full_hits);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver stall: a random wait after each transfer, and one long hold-off mid-run.
  initial begin
    int wait_left;
    bit held;
    wait_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent >= 700) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        wait_left = 0;
      end
      if (result_taken) begin
        result_taken = 1'b0;
        wait_left = idle_free ? 0 : $urandom_range(0, 5);
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      result_taken = 1'b1;
      received++;
      if (pending_q.size() == 0) begin
        report("results outstanding", 0, 1);
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.st) report("status", out_status, e.st);
        if (out_list_length !== e.len) report("list length", out_list_length, e.len);
        if (out_cursor_position !== e.pos)
          report("cursor position", out_cursor_position, e.pos);
        if (out_cursor_value !== e.cur) report("cursor value", out_cursor_value, e.cur);
        if (out_front_value !== e.frt) report("front value", out_front_value, e.frt);
        if (out_back_value !== e.bck) report("back value", out_back_value, e.bck);
      end
    end
  end

  // Run-time limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, pending_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+src
src/cle_pkg.sv
src/cle_ram.sv
src/cursor_list_engine.sv
tb/cursor_list_engine_tb.sv
